### rtl/core/sfn_pkg.sv
// Shared constants, types and helpers for the stochastic fire network step block.
package sfn_pkg;

  localparam int NEURONS   = 256;
  localparam int NEURON_W  = $clog2(NEURONS);
  localparam int WORD_W    = 64;
  localparam int ROW_WORDS = (NEURONS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = $clog2(ROW_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int MAT_DEPTH = NEURONS * ROW_WORDS;
  localparam int MAT_AW    = NEURON_W + WIDX_W;
  localparam int DEG_W     = 9;
  localparam int CNT_W     = 9;
  localparam int PC_W      = BIT_W + 1;
  localparam int FRAC_W    = 32;
  localparam int STR_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int PA_W      = FRAC_W + DEG_W;
  localparam int PB_W      = STR_W + CNT_W;
  localparam int CMP_W     = PB_W + 16;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_EVAL = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXT_THR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 1'd1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_EVAL_RD,
    S_EVAL_ACC,
    S_EVAL_MUL,
    S_EVAL_CMP,
    S_TICK,
    S_DONE
  } state_t;

  typedef logic [ROW_WORDS-1:0][WORD_W-1:0] bitset_t;

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_W-1:0] x);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + PC_W'(x[i]);
    end
    return c;
  endfunction

endpackage

### rtl/core/sfn_if.sv
// Item channel interfaces: request items in, result items out.
interface sfn_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [sfn_pkg::NEURON_W-1:0]  source_index;
  logic [sfn_pkg::NEURON_W-1:0]  target_index;
  logic [sfn_pkg::FRAC_W-1:0]    draw_external;
  logic [sfn_pkg::FRAC_W-1:0]    draw_internal;

  modport source(output valid, req_type, source_index, target_index, draw_external,
                 draw_internal, input ready);
  modport sink(input valid, req_type, source_index, target_index, draw_external,
               draw_internal, output ready);
endinterface

interface sfn_out_if;
  logic                       valid;
  logic                       ready;
  logic                       result_is_tick;
  logic                       fired;
  logic [sfn_pkg::CNT_W-1:0]  active_count;

  modport source(output valid, result_is_tick, fired, active_count, input ready);
  modport sink(input valid, result_is_tick, fired, active_count, output ready);
endinterface

### rtl/core/stochastic_fire_network_step_top.sv
// Top level of the stochastic fire network step block.
// One item at a time. After reset a clearing pass zeroes the connection matrix
// and in-degree memories; no item is taken meanwhile. An edge load reads, then
// writes back the matrix word and degree, then goes idle. An evaluation makes
// four reads of the neuron's 64-bit row words through the single matrix read
// port, then the last AND/popcount accumulation, one multiply stage, the
// compare, the hand-off to the output register and idle. A commit counts the
// new active set one 64-bit word per cycle. A finished result sits in an output
// register, so the next item is taken while it waits; a second result that
// finds that register still full holds the block, and no item is taken, until
// the first one leaves.
module stochastic_fire_network_step_top (
  input  logic                              clk,
  input  logic                              rst_n,
  sfn_in_if.sink                            in_chan,
  sfn_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [sfn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sfn_pkg::state_t                 state_r, state_nxt;
  logic [sfn_pkg::MAT_AW-1:0]      clr_r, clr_nxt;
  logic [sfn_pkg::WIDX_W-1:0]      widx_r, widx_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic [sfn_pkg::WIDX_W-1:0]      rd_w_r, rd_w_nxt;
  logic [sfn_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  sfn_pkg::bitset_t                active_r, active_nxt;
  sfn_pkg::bitset_t                pending_r, pending_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_tick_r, out_tick_nxt;
  logic                            out_fired_r, out_fired_nxt;
  logic [sfn_pkg::CNT_W-1:0]       out_count_r, out_count_nxt;
  logic                            res_tick_r, res_tick_nxt;
  logic                            res_fired_r, res_fired_nxt;

  logic [sfn_pkg::NEURON_W-1:0]    src_r, src_nxt;
  logic [sfn_pkg::NEURON_W-1:0]    tgt_r, tgt_nxt;
  logic [sfn_pkg::FRAC_W-1:0]      dext_r, dext_nxt;
  logic [sfn_pkg::FRAC_W-1:0]      dint_r, dint_nxt;
  logic [sfn_pkg::PA_W-1:0]        prod_a_r, prod_a_nxt;
  logic [sfn_pkg::PB_W-1:0]        prod_b_r, prod_b_nxt;

  logic [sfn_pkg::FRAC_W-1:0]      ext_thr_r;
  logic [sfn_pkg::STR_W-1:0]       strength_r;

  logic                            mat_we, mat_re;
  logic [sfn_pkg::MAT_AW-1:0]      mat_waddr, mat_raddr;
  logic [sfn_pkg::WORD_W-1:0]      mat_wdata, mat_q;
  logic                            deg_we, deg_re;
  logic [sfn_pkg::NEURON_W-1:0]    deg_waddr, deg_raddr;
  logic [sfn_pkg::DEG_W-1:0]       deg_wdata, deg_q;

  logic                            in_acc;
  logic [sfn_pkg::WORD_W-1:0]      src_mask;
  logic [sfn_pkg::WORD_W-1:0]      hit_word;
  logic                            fire;

  sfn_ram #(.WIDTH(sfn_pkg::WORD_W), .DEPTH(sfn_pkg::MAT_DEPTH)) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .re    (mat_re),
    .raddr (mat_raddr),
    .rdata (mat_q)
  );

  sfn_ram #(.WIDTH(sfn_pkg::DEG_W), .DEPTH(sfn_pkg::NEURONS)) u_deg (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_q)
  );

  assign in_chan.ready           = (state_r == sfn_pkg::S_IDLE);
  assign in_acc                  = in_chan.valid && in_chan.ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_is_tick = out_tick_r;
  assign out_chan.fired          = out_fired_r;
  assign out_chan.active_count   = out_count_r;

  assign src_mask = sfn_pkg::WORD_W'(1) << src_r[sfn_pkg::BIT_W-1:0];
  assign hit_word = mat_q & active_r[rd_w_r];
  assign fire     = (dext_r < ext_thr_r) ||
                    ({8'd0, prod_a_r} < {prod_b_r, 16'd0});

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    widx_nxt      = widx_r;
    rd_pend_nxt   = 1'b0;
    rd_w_nxt      = rd_w_r;
    cnt_nxt       = cnt_r;
    active_nxt    = active_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_tick_nxt  = out_tick_r;
    out_fired_nxt = out_fired_r;
    out_count_nxt = out_count_r;
    res_tick_nxt  = res_tick_r;
    res_fired_nxt = res_fired_r;
    src_nxt       = src_r;
    tgt_nxt       = tgt_r;
    dext_nxt      = dext_r;
    dint_nxt      = dint_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    mat_we        = 1'b0;
    mat_waddr     = {tgt_r, src_r[sfn_pkg::NEURON_W-1:sfn_pkg::BIT_W]};
    mat_wdata     = mat_q | src_mask;
    mat_re        = 1'b0;
    mat_raddr     = {tgt_r, widx_r};
    deg_we        = 1'b0;
    deg_waddr     = tgt_r;
    deg_wdata     = deg_q + sfn_pkg::DEG_W'(1);
    deg_re        = 1'b0;
    deg_raddr     = tgt_r;

    if (rd_pend_r) begin
      cnt_nxt = cnt_r + sfn_pkg::CNT_W'(sfn_pkg::popcount(hit_word));
    end

    case (state_r)
      sfn_pkg::S_CLR: begin
        mat_we    = 1'b1;
        mat_waddr = clr_r;
        mat_wdata = '0;
        deg_we    = 1'b1;
        deg_waddr = clr_r[sfn_pkg::NEURON_W-1:0];
        deg_wdata = '0;
        clr_nxt   = clr_r + sfn_pkg::MAT_AW'(1);
        if (clr_r == sfn_pkg::MAT_AW'(sfn_pkg::MAT_DEPTH - 1)) begin
          state_nxt = sfn_pkg::S_IDLE;
        end
      end
      sfn_pkg::S_IDLE: begin
        if (in_acc) begin
          src_nxt  = in_chan.source_index;
          tgt_nxt  = in_chan.target_index;
          dext_nxt = in_chan.draw_external;
          dint_nxt = in_chan.draw_internal;
          widx_nxt = '0;
          cnt_nxt  = '0;
          case (in_chan.req_type)
            sfn_pkg::REQ_LOAD: state_nxt = sfn_pkg::S_LOAD_RD;
            sfn_pkg::REQ_EVAL: state_nxt = sfn_pkg::S_EVAL_RD;
            sfn_pkg::REQ_TICK: begin
              active_nxt  = pending_r;
              pending_nxt = '0;
              state_nxt   = sfn_pkg::S_TICK;
            end
            default: state_nxt = sfn_pkg::S_IDLE;
          endcase
        end
      end
      sfn_pkg::S_LOAD_RD: begin
        mat_re    = 1'b1;
        mat_raddr = {tgt_r, src_r[sfn_pkg::NEURON_W-1:sfn_pkg::BIT_W]};
        deg_re    = 1'b1;
        state_nxt = sfn_pkg::S_LOAD_WR;
      end
      sfn_pkg::S_LOAD_WR: begin
        if ((src_r != tgt_r) && ((mat_q & src_mask) == '0)) begin
          mat_we = 1'b1;
          deg_we = 1'b1;
        end
        state_nxt = sfn_pkg::S_IDLE;
      end
      sfn_pkg::S_EVAL_RD: begin
        mat_re      = 1'b1;
        deg_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        rd_w_nxt    = widx_r;
        widx_nxt    = widx_r + sfn_pkg::WIDX_W'(1);
        if (widx_r == sfn_pkg::WIDX_W'(sfn_pkg::ROW_WORDS - 1)) begin
          state_nxt = sfn_pkg::S_EVAL_ACC;
        end
      end
      sfn_pkg::S_EVAL_ACC: begin
        state_nxt = sfn_pkg::S_EVAL_MUL;
      end
      sfn_pkg::S_EVAL_MUL: begin
        prod_a_nxt = sfn_pkg::PA_W'(dint_r) * sfn_pkg::PA_W'(deg_q);
        prod_b_nxt = sfn_pkg::PB_W'(strength_r) * sfn_pkg::PB_W'(cnt_r);
        state_nxt  = sfn_pkg::S_EVAL_CMP;
      end
      sfn_pkg::S_EVAL_CMP: begin
        if (fire) begin
          pending_nxt[tgt_r[sfn_pkg::NEURON_W-1:sfn_pkg::BIT_W]]
                     [tgt_r[sfn_pkg::BIT_W-1:0]] = 1'b1;
        end
        res_tick_nxt  = 1'b0;
        res_fired_nxt = fire;
        state_nxt     = sfn_pkg::S_DONE;
      end
      sfn_pkg::S_TICK: begin
        cnt_nxt  = cnt_r + sfn_pkg::CNT_W'(sfn_pkg::popcount(active_r[widx_r]));
        widx_nxt = widx_r + sfn_pkg::WIDX_W'(1);
        if (widx_r == sfn_pkg::WIDX_W'(sfn_pkg::ROW_WORDS - 1)) begin
          res_tick_nxt  = 1'b1;
          res_fired_nxt = 1'b0;
          state_nxt     = sfn_pkg::S_DONE;
        end
      end
      sfn_pkg::S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_tick_nxt  = res_tick_r;
          out_fired_nxt = res_fired_r;
          out_count_nxt = res_tick_r ? cnt_r : '0;
          state_nxt     = sfn_pkg::S_IDLE;
        end
      end
      default: state_nxt = sfn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfn_pkg::S_CLR;
      clr_r       <= '0;
      widx_r      <= '0;
      rd_pend_r   <= 1'b0;
      rd_w_r      <= '0;
      cnt_r       <= '0;
      active_r    <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
      res_tick_r  <= 1'b0;
      res_fired_r <= 1'b0;
      ext_thr_r   <= '0;
      strength_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      widx_r      <= widx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_w_r      <= rd_w_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      res_tick_r  <= res_tick_nxt;
      res_fired_r <= res_fired_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sfn_pkg::CFG_EXT_THR:  ext_thr_r  <= cfg_data;
          sfn_pkg::CFG_STRENGTH: strength_r <= cfg_data[sfn_pkg::STR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tick_r  <= out_tick_nxt;
    out_fired_r <= out_fired_nxt;
    out_count_r <= out_count_nxt;
    src_r       <= src_nxt;
    tgt_r       <= tgt_nxt;
    dext_r      <= dext_nxt;
    dint_r      <= dint_nxt;
    prod_a_r    <= prod_a_nxt;
    prod_b_r    <= prod_b_nxt;
  end

endmodule

### rtl/core/sfn_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module sfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/sfn_checker.sv
// Port-level assertions for the stochastic fire network step block, with bind.
module sfn_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_tick,
  input logic                       out_fired,
  input logic [sfn_pkg::CNT_W-1:0]  out_count
);

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("item accepted during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_eval_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tick |-> out_count == '0)
    else $error("evaluation result carries a count");

  a_tick_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tick |-> !out_fired &&
      out_count <= sfn_pkg::CNT_W'(sfn_pkg::NEURONS))
    else $error("bad commit result");

endmodule

bind stochastic_fire_network_step_top sfn_checker u_sfn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_tick  (out_chan.result_is_tick),
  .out_fired (out_chan.fired),
  .out_count (out_chan.active_count)
);

### bench/tb.sv
// Testbench for stochastic_fire_network_step_top: directed table plus clustered random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfn_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          req;
    logic [NEURON_W-1:0] src;
    logic [NEURON_W-1:0] tgt;
    logic [FRAC_W-1:0]   dext;
    logic [FRAC_W-1:0]   dint;
  } net_req_t;

  typedef struct packed {
    logic             is_tick;
    logic             fired;
    logic [CNT_W-1:0] count;
  } net_res_t;

  typedef struct packed {
    net_req_t item;
    logic     typed;
    net_res_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfn_in_if in_chan();
  sfn_out_if out_chan();

  stochastic_fire_network_step_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // network shadow
  logic [NEURONS-1:0] net_edges [NEURONS];
  logic [DEG_W-1:0]   net_indeg [NEURONS];
  logic [NEURONS-1:0] net_active;
  logic [NEURONS-1:0] net_pending;
  logic [FRAC_W-1:0]  thr_q;
  logic [STR_W-1:0]   str_q;

  net_res_t  due_results [$];
  stim_row_t directed_rows [0:19];
  int        fail_count;
  int        tx_idle;
  int        rx_stall;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  function automatic bit step_network(input net_req_t it, output net_res_t res);
    int          cnt;
    logic [63:0] lhs;
    logic [63:0] rhs;
    bit          fire;
    res = '0;
    case (it.req)
      REQ_LOAD: begin
        if (it.src != it.tgt && !net_edges[it.tgt][it.src]) begin
          net_edges[it.tgt][it.src] = 1'b1;
          net_indeg[it.tgt] = net_indeg[it.tgt] + 1'b1;
        end
        return 1'b0;
      end
      REQ_EVAL: begin
        fire = 1'b0;
        if (it.dext < thr_q) begin
          fire = 1'b1;
        end else begin
          cnt = $countones(net_edges[it.tgt] & net_active);
          lhs = 64'(it.dint) * 64'(net_indeg[it.tgt]);
          rhs = (64'(str_q) * 64'(cnt)) << 16;
          fire = lhs < rhs;
        end
        if (fire) net_pending[it.tgt] = 1'b1;
        res.fired = fire;
        return 1'b1;
      end
      REQ_TICK: begin
        net_active = net_pending;
        net_pending = '0;
        cnt = $countones(net_active);
        res.is_tick = 1'b1;
        res.count = (cnt > 511) ? CNT_W'(511) : CNT_W'(cnt);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic push_item(input net_req_t it, input logic typed, input net_res_t typed_res);
    net_res_t res;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= it.req;
    in_chan.source_index  <= it.src;
    in_chan.target_index  <= it.tgt;
    in_chan.draw_external <= it.dext;
    in_chan.draw_internal <= it.dint;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (step_network(it, res))
      due_results.insert(due_results.size(), typed ? typed_res : res);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_config(input logic [FRAC_W-1:0] thr, input logic [STR_W-1:0] str);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXT_THR;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_STRENGTH;
    cfg_data  <= CFG_DATA_W'(str);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_q = thr;
    str_q = str;
  endtask

  // traffic stays mostly inside a small cluster of neurons so that activity spreads
  task automatic run_random(input int n);
    net_req_t it;
    int       base;
    int       span;
    int       left;
    int       pick;
    int       done;
    left = 0;
    done = 0;
    while (done < n) begin
      if (left == 0) begin
        base = $urandom_range(0, 255);
        span = $urandom_range(4, 20);
        left = $urandom_range(30, 80);
      end
      left--;
      pick = $urandom_range(0, 99);
      it.src  = NEURON_W'(base + $urandom_range(0, span - 1));
      it.tgt  = NEURON_W'(base + $urandom_range(0, span - 1));
      it.dext = $urandom;
      it.dint = $urandom;
      if ($urandom_range(0, 19) == 0) it.dext = thr_q - $urandom_range(0, 1);
      if (pick < 6) begin
        it.req = REQ_UNUSED;
        it.src = NEURON_W'($urandom);
        it.tgt = NEURON_W'($urandom);
      end else if (pick < 34) begin
        it.req = REQ_LOAD;
      end else if (pick < 84) begin
        it.req = REQ_EVAL;
      end else if (pick < 94) begin
        it.req = REQ_TICK;
      end else begin
        it.req = $urandom_range(0, 1) ? REQ_EVAL : REQ_LOAD;
        it.src = NEURON_W'($urandom);
        it.tgt = NEURON_W'($urandom);
      end
      push_item(it, 1'b0, '0);
      if (it.req != REQ_UNUSED) done++;
    end
  endtask

  task automatic run_phase(input logic [FRAC_W-1:0] thr, input logic [STR_W-1:0] str,
                           input int tx, input int rx, input int n, input bit flood);
    net_req_t it;
    drain();
    set_config(thr, str);
    tx_idle  = tx;
    rx_stall = rx;
    if (flood) begin
      for (int k = 0; k < NEURONS; k++) begin
        it.req  = REQ_EVAL;
        it.src  = NEURON_W'($urandom);
        it.tgt  = NEURON_W'(k);
        it.dext = $urandom_range(0, 32'hFFFF_FFFE);
        it.dint = $urandom;
        push_item(it, 1'b0, '0);
      end
      it.req = REQ_TICK;
      push_item(it, 1'b0, '0);
    end
    run_random(n);
  endtask

  always @(posedge clk) begin : result_check
    net_res_t got;
    net_res_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = '{out_chan.result_is_tick, out_chan.fired, out_chan.active_count};
      if (due_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: tick=%0b fired=%0b count=%0d",
                   got.is_tick, got.fired, got.count);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("mismatch: expected tick=%0b fired=%0b count=%0d,",
                     want.is_tick, want.fired, want.count,
                     " got tick=%0b fired=%0b count=%0d",
                     got.is_tick, got.fired, got.count);
          fail_count++;
        end
      end
    end
    out_chan.ready <= ($urandom_range(0, 99) >= rx_stall);
  end

  initial begin
    fail_count = 0;
    tx_idle    = 0;
    rx_stall   = 0;
    for (int k = 0; k < NEURONS; k++) begin
      net_edges[k] = '0;
      net_indeg[k] = '0;
    end
    net_active  = '0;
    net_pending = '0;
    thr_q = '0;
    str_q = '0;

    directed_rows[0]  = '{'{REQ_TICK, 8'h00, 8'h00, 32'h0, 32'h0}, 1'b1, '{1'b1, 1'b0, 9'd0}};
    directed_rows[1]  = '{'{REQ_EVAL, 8'h00, 8'h00, 32'h0, 32'h0}, 1'b1, '{1'b0, 1'b1, 9'd0}};
    directed_rows[2]  = '{'{REQ_EVAL, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                          '{1'b0, 1'b0, 9'd0}};
    directed_rows[3]  = '{'{REQ_TICK, 8'h00, 8'h00, 32'h0, 32'h0}, 1'b1, '{1'b1, 1'b0, 9'd1}};
    directed_rows[4]  = '{'{REQ_LOAD, 8'h00, 8'h01, 32'h0, 32'h0}, 1'b0, '0};
    // repeated edge, then a self edge
    directed_rows[5]  = '{'{REQ_LOAD, 8'h00, 8'h01, 32'h0, 32'h0}, 1'b0, '0};
    directed_rows[6]  = '{'{REQ_LOAD, 8'h02, 8'h02, 32'h0, 32'h0}, 1'b0, '0};
    directed_rows[7]  = '{'{REQ_LOAD, 8'hFF, 8'h01, 32'h0, 32'h0}, 1'b0, '0};
    directed_rows[8]  = '{'{REQ_LOAD, 8'h00, 8'hFF, 32'h0, 32'h0}, 1'b0, '0};
    directed_rows[9]  = '{'{REQ_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0};
    directed_rows[10] = '{'{REQ_EVAL, 8'h00, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0};
    directed_rows[11] = '{'{REQ_EVAL, 8'h00, 8'h01, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0};
    directed_rows[12] = '{'{REQ_EVAL, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0};
    // draw equal to threshold, no in-neighbours
    directed_rows[13] = '{'{REQ_EVAL, 8'h00, 8'h02, 32'h8000_0000, 32'h0}, 1'b0, '0};
    directed_rows[14] = '{'{REQ_EVAL, 8'h00, 8'h03, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0};
    directed_rows[15] = '{'{REQ_TICK, 8'h00, 8'h00, 32'h0, 32'h0}, 1'b0, '0};
    directed_rows[16] = '{'{REQ_EVAL, 8'h00, 8'h01, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0};
    directed_rows[17] = '{'{REQ_EVAL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0};
    directed_rows[18] = '{'{REQ_LOAD, 8'hAA, 8'h55, 32'h0, 32'h0}, 1'b0, '0};
    directed_rows[19] = '{'{REQ_EVAL, 8'hAA, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0};

    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_EXT_THR;
    cfg_data              <= '0;
    in_chan.valid         <= 1'b0;
    in_chan.req_type      <= REQ_LOAD;
    in_chan.source_index  <= '0;
    in_chan.target_index  <= '0;
    in_chan.draw_external <= '0;
    in_chan.draw_internal <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(32'h8000_0000, 24'h01_0000);
    foreach (directed_rows[k])
      push_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].res);

    run_phase(32'h3000_0000, 24'h02_0000, 0, 0, 100, 1'b0);
    run_phase(32'h0000_0000, 24'hFF_FFFF, 74, 0, 90, 1'b0);
    run_phase(32'hFFFF_FFFF, 24'h00_0000, 0, 74, 40, 1'b1);
    run_phase(32'h1000_0000, 24'h00_8000, 19, 19, 100, 1'b0);
    run_phase(32'h6000_0000, 24'h10_0000, 0, 0, 70, 1'b0);
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
